/* src/tmt_pkg.sv */
// Shared types and constants for the timer migration tracker.
package tmt_pkg;

  localparam int TableDepth = 2048;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = $clog2(TableDepth + 1);

  localparam logic [1:0] CmdStart  = 2'd0;
  localparam logic [1:0] CmdCancel = 2'd1;
  localparam logic [1:0] CmdExpire = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  cpu_id;
    logic [63:0] stamp;
    logic [63:0] timer_key;
  } item_t;

  typedef struct packed {
    logic        valid;
    item_t       item;
  } queue_head_t;

  typedef struct packed {
    logic [63:0] key;
    logic [4:0]  cpu;
    logic        busy;
    logic [63:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } back_state_t;

endpackage

/* src/tmt_front.sv */
// Front end: accepts event words and holds them in a two-entry queue.
module tmt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tmt_pkg::item_t      item,
  input  logic                pop,
  output logic                busy,
  output tmt_pkg::queue_head_t head
);
  import tmt_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign head.valid = (count != 2'd0);
  assign head.item = q[rd_ptr];

  // store accepted words
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && head.valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop && head.valid};
    end
  end
endmodule

/* src/tmt_back.sv */
// Back end: scans the timer table, updates it and produces one result per event.
module tmt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tmt_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 done,
  output logic                 moved_flag,
  output logic [4:0]           start_cpu,
  output logic [63:0]          start_stamp,
  output logic                 unknown_flag,
  output logic                 full_flag,
  output logic [31:0]          started_total,
  output logic [31:0]          moved_total,
  output logic [31:0]          canceled_total,
  output logic [31:0]          expired_total,
  output logic [31:0]          unknown_total
);
  import tmt_pkg::*;

  entry_t      mem [TableDepth];
  entry_t      rdata;
  logic [AddrW-1:0] raddr;
  logic        we;
  logic [AddrW-1:0] waddr;
  entry_t      wdata;

  back_state_t state, state_next;
  item_t       cur;
  logic [CountW-1:0] used_count;
  logic [CountW-1:0] scan_addr;
  logic        rd_pend;
  logic [AddrW-1:0] rd_idx;
  logic        hit;
  logic [AddrW-1:0] hit_idx;
  entry_t      hit_e;
  logic        free_found;
  logic [AddrW-1:0] free_idx;
  logic        match_now;
  logic        issue;
  logic        scan_end;
  logic [31:0] started_count, moved_count, canceled_count, expired_count, unknown_count;

  assign match_now = rd_pend && (rdata.key == cur.timer_key);
  assign issue = (state == ST_SCAN) && !match_now && (scan_addr < used_count);
  assign scan_end = (state == ST_SCAN) && (match_now || (!rd_pend && !issue));
  assign raddr = scan_addr[AddrW-1:0];

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (head.valid) state_next = ST_SCAN;
      ST_SCAN:   if (scan_end) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop = 1'b0;
    unique case (state)
      ST_IDLE:   pop = head.valid;
      ST_SCAN:   pop = 1'b0;
      ST_FINISH: pop = 1'b0;
      default:   pop = 1'b0;
    endcase
  end

  // table write for the finishing event
  always_comb begin
    we = 1'b0;
    waddr = hit_idx;
    wdata = hit_e;
    if (state == ST_FINISH) begin
      case (cur.cmd) inside
        CmdStart: begin
          wdata = '{key: cur.timer_key, cpu: cur.cpu_id, busy: 1'b1, stamp: cur.stamp};
          if (hit) begin
            we = 1'b1;
          end else if (free_found) begin
            we = 1'b1;
            waddr = free_idx;
          end else if (used_count < CountW'(TableDepth)) begin
            we = 1'b1;
            waddr = used_count[AddrW-1:0];
          end
        end
        CmdCancel, CmdExpire: begin
          we = hit;
          wdata.busy = 1'b0;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur <= (state == ST_IDLE) ? head.item : cur;
  end

  // scan bookkeeping, table fill and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used_count <= '0;
      scan_addr <= '0;
      rd_pend <= 1'b0;
      rd_idx <= '0;
      hit <= 1'b0;
      hit_idx <= '0;
      free_found <= 1'b0;
      free_idx <= '0;
      started_count <= '0;
      moved_count <= '0;
      canceled_count <= '0;
      expired_count <= '0;
      unknown_count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == ST_IDLE) begin
        scan_addr <= '0;
        rd_pend <= 1'b0;
        hit <= 1'b0;
        free_found <= 1'b0;
      end
      if (state == ST_SCAN) begin
        rd_pend <= issue;
        rd_idx <= scan_addr[AddrW-1:0];
        if (issue) begin
          scan_addr <= scan_addr + CountW'(1);
        end
        if (match_now) begin
          hit <= 1'b1;
          hit_idx <= rd_idx;
          hit_e <= rdata;
        end
        if (rd_pend && !rdata.busy) begin
          free_found <= 1'b1;
          free_idx <= rd_idx;
        end
      end
      if (state == ST_FINISH) begin
        done <= 1'b1;
        moved_flag <= 1'b0;
        start_cpu <= '0;
        start_stamp <= '0;
        unknown_flag <= 1'b0;
        full_flag <= 1'b0;
        started_total <= started_count;
        moved_total <= moved_count;
        canceled_total <= canceled_count;
        expired_total <= expired_count;
        unknown_total <= unknown_count;
        case (cur.cmd)
          CmdStart: begin
            started_count <= started_count + 32'd1;
            started_total <= started_count + 32'd1;
            if (!hit && !free_found) begin
              if (used_count < CountW'(TableDepth)) begin
                used_count <= used_count + CountW'(1);
              end else begin
                full_flag <= 1'b1;
              end
            end
          end
          CmdCancel: begin
            canceled_count <= canceled_count + 32'd1;
            canceled_total <= canceled_count + 32'd1;
          end
          CmdExpire: begin
            expired_count <= expired_count + 32'd1;
            expired_total <= expired_count + 32'd1;
            if (!hit) begin
              unknown_count <= unknown_count + 32'd1;
              unknown_total <= unknown_count + 32'd1;
              unknown_flag <= 1'b1;
            end else if (hit_e.busy && (hit_e.cpu != cur.cpu_id)) begin
              moved_count <= moved_count + 32'd1;
              moved_total <= moved_count + 32'd1;
              moved_flag <= 1'b1;
              start_cpu <= hit_e.cpu;
              start_stamp <= hit_e.stamp;
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CountW'(TableDepth)) else $error("fill count beyond table depth");
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH)) else $error("result without finishing event");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(moved_flag && unknown_flag)) else $error("moved and unknown together");
endmodule

/* src/timer_migration_tracker.sv */
// Top level of the timer migration tracker.
//
// Usage: drive cmd, cpu_id, stamp and timer_key with start high; the word is
// taken at a rising edge where start is high and busy is low. A two-word queue
// sits between the input side and the table engine, so busy rises only when
// two words wait behind the one at work.
// Each word yields one result, shown for exactly one cycle with done high;
// the receiver cannot stall and must take it then.
// The table engine scans up to used_count slots, the number of table slots
// ever used (up to 2048). It reads one slot per cycle from a table memory
// with one read and one write port and stops at the first key match; it
// works on one word at a time and takes the next only once the last is done.
// Reset (rst, synchronous) empties the queue and zeroes the fill count and
// the counters behind the five totals. Table contents need no clearing:
// only slots below the fill count are ever read.
module timer_migration_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [4:0]  cpu_id,
  input  logic [63:0] stamp,
  input  logic [63:0] timer_key,
  output logic        done,
  output logic        moved_flag,
  output logic [4:0]  start_cpu,
  output logic [63:0] start_stamp,
  output logic        unknown_flag,
  output logic        full_flag,
  output logic [31:0] started_total,
  output logic [31:0] moved_total,
  output logic [31:0] canceled_total,
  output logic [31:0] expired_total,
  output logic [31:0] unknown_total
);
  import tmt_pkg::*;

  item_t       item;
  queue_head_t head;
  logic        pop;

  assign item = '{cmd: cmd, cpu_id: cpu_id, stamp: stamp, timer_key: timer_key};

  tmt_front u_front (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .pop(pop), .busy(busy), .head(head)
  );

  tmt_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .done(done),
    .moved_flag(moved_flag), .start_cpu(start_cpu), .start_stamp(start_stamp),
    .unknown_flag(unknown_flag), .full_flag(full_flag),
    .started_total(started_total), .moved_total(moved_total),
    .canceled_total(canceled_total), .expired_total(expired_total),
    .unknown_total(unknown_total)
  );
endmodule
